// ===== src/tsrm_pkg.sv =====
`default_nettype none

package tsrm_pkg;

    localparam int NREGS = 22;
    localparam int IDX_W = $clog2(NREGS);

    typedef logic [IDX_W-1:0] reg_idx_t;

    // Target index meaning "no register selected"; any index >= NREGS reads as none.
    localparam reg_idx_t NO_TARGET = '1;

    // Bus event codes
    localparam logic [1:0] CMD_ADDR  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_TEMP  = 2'd3;

    // Pointer addresses carry a ninth bit flagging "no address of this kind".
    localparam logic [8:0] NO_ADDR = 9'h100;

    localparam logic [8:0] RD_ADDR [NREGS] = '{
        9'h000, 9'h001, 9'h002, 9'h003, 9'h004, 9'h005, 9'h006, 9'h007,
        9'h008, NO_ADDR, 9'h010, 9'h011, 9'h012, 9'h013, 9'h014, 9'h015,
        9'h019, 9'h020, 9'h021, 9'h022, 9'h023, 9'h0fe
    };

    localparam logic [8:0] WR_ADDR [NREGS] = '{
        NO_ADDR, NO_ADDR, NO_ADDR, 9'h009, 9'h00a, 9'h00b, 9'h00c, 9'h00d,
        9'h00e, 9'h00f, NO_ADDR, 9'h011, 9'h012, 9'h013, 9'h014, NO_ADDR,
        9'h019, 9'h020, 9'h021, 9'h022, 9'h023, NO_ADDR
    };

    localparam logic [7:0] RESET_VAL [NREGS] = '{
        8'h00, 8'h00, 8'h00, 8'h04, 8'h08, 8'h55, 8'h00, 8'h55,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h6c, 8'h55, 8'h0a, 8'h01, 8'h00, 8'h59
    };

    // Configuration register and its range-select bit
    localparam int CFG_REG   = 3;
    localparam int RANGE_BIT = 2;

    typedef struct packed {
        reg_idx_t rd;
        reg_idx_t wr;
    } ptr_sel_t;

    typedef struct packed {
        logic       en;
        reg_idx_t   idx;
        logic [7:0] data;
    } rf_wr_t;

    // Pointer byte to read/write targets; first match in register order wins,
    // read address checked before write address.
    function automatic ptr_sel_t decode_pointer(logic [7:0] d);
        ptr_sel_t sel;
        logic     found;
        sel.rd = NO_TARGET;
        sel.wr = NO_TARGET;
        found  = 1'b0;
        for (int i = 0; i < NREGS; i++) begin
            if (!found) begin
                if (RD_ADDR[i] == {1'b0, d}) begin
                    sel.rd = reg_idx_t'(i);
                    sel.wr = (WR_ADDR[i] == RD_ADDR[i]) ? reg_idx_t'(i) : NO_TARGET;
                    found  = 1'b1;
                end
                else if (WR_ADDR[i] == {1'b0, d}) begin
                    sel.rd = NO_TARGET;
                    sel.wr = reg_idx_t'(i);
                    found  = 1'b1;
                end
            end
        end
        return sel;
    endfunction

    // Clamp and encode a temperature: extended range adds 64 over -64..191,
    // normal range clamps to 0..127.
    function automatic logic [7:0] encode_temp(logic signed [8:0] t, logic ext);
        logic signed [9:0] biased;
        logic [7:0]        r;
        biased = 10'(t) + 10'sd64;
        if (ext) begin
            if (t < -9'sd64)
                r = 8'd0;
            else if (t > 9'sd191)
                r = 8'd255;
            else
                r = biased[7:0];
        end
        else begin
            if (t < 9'sd0)
                r = 8'd0;
            else if (t > 9'sd127)
                r = 8'd127;
            else
                r = t[7:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/tsrm_regfile.sv =====
`default_nettype none

module tsrm_regfile
    import tsrm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire rf_wr_t     wr,
    input  wire reg_idx_t   rd_idx,
    output logic [7:0]      rd_data,
    output logic            ext_range
);

    logic [7:0] regs_reg [NREGS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NREGS; i++)
            begin
                regs_reg[i] <= RESET_VAL[i];
            end
        end
        else if (wr.en && (wr.idx < reg_idx_t'(NREGS)))
        begin
            regs_reg[wr.idx] <= wr.data;
        end
    end

    // Out-of-range target reads as zero
    assign rd_data   = (rd_idx < reg_idx_t'(NREGS)) ? regs_reg[rd_idx] : 8'd0;
    assign ext_range = regs_reg[CFG_REG][RANGE_BIT];

endmodule

`default_nettype wire

// ===== src/temp_sensor_slave_register_map.sv =====
`default_nettype none

// Slave-side register map of a remote-diode temperature sensor on SMBus. Each
// transfer on the cmd channel is one bus event: an address match (is_write set
// arms the pointer), a written byte (the first after an armed address picks the
// read and write targets, later ones store into the write target), a read byte
// (answered with one transfer of read_data on the rsp channel) or a temperature
// update. Registers 0 and 1 read back the held remote and local temperatures,
// clamped and encoded in extended range (offset 64) when bit 2 of register 3 is
// set, else in normal range 0..127. A read with no target returns zero. One
// transfer is taken every cycle while cmd_stall is low; each event is
// registered at the input, then decoded and applied by a single short logic
// stage, so a read result moves from the input stage into the rsp output
// register and is held there while rsp_stall is set. cmd_stall rises only
// while a read sits in the input stage and the previous result is still held
// by rsp_stall. No clearing pass after reset.
module temp_sensor_slave_register_map
    import tsrm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // event channel
    input  wire logic              cmd_valid,
    output logic                   cmd_stall,
    input  wire logic [1:0]        command,
    input  wire logic              is_write,
    input  wire logic [7:0]        data_byte,
    input  wire logic signed [8:0] remote_reading,
    input  wire logic signed [8:0] local_reading,
    // result channel
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output logic [7:0]             read_data
);

    // Input stage
    logic                   s1_valid_reg, s1_valid_next;
    logic [1:0]             s1_cmd_reg;
    logic                   s1_is_write_reg;
    logic [7:0]             s1_data_reg;
    logic signed [8:0]      s1_remote_reg;
    logic signed [8:0]      s1_local_reg;

    // Protocol state
    logic                   pending_reg, pending_next;
    reg_idx_t               rd_target_reg, rd_target_next;
    reg_idx_t               wr_target_reg, wr_target_next;
    logic signed [8:0]      held_remote_reg, held_remote_next;
    logic signed [8:0]      held_local_reg, held_local_next;

    // Result register
    logic                   rsp_valid_reg, rsp_valid_next;
    logic [7:0]             read_data_reg, read_data_next;

    logic                   cmd_take;
    logic                   s1_adv;
    logic                   s1_is_read;
    ptr_sel_t               ptr_sel;
    rf_wr_t                 rf_wr;
    logic [7:0]             rf_rd_data;
    logic                   ext_range;
    logic [7:0]             rd_value;

    // A read may only leave the input stage when the result register is free
    assign s1_is_read = (s1_cmd_reg == CMD_READ);
    assign s1_adv     = s1_valid_reg && !(s1_is_read && rsp_valid_reg && rsp_stall);
    assign cmd_stall  = s1_valid_reg && !s1_adv;
    assign cmd_take   = cmd_valid && !cmd_stall;

    assign ptr_sel = decode_pointer(s1_data_reg);

    tsrm_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (rf_wr),
        .rd_idx    (rd_target_reg),
        .rd_data   (rf_rd_data),
        .ext_range (ext_range)
    );

    // Temperature registers override the stored bytes
    always_comb
    begin
        priority if (rd_target_reg == reg_idx_t'(0))
            rd_value = encode_temp(held_remote_reg, ext_range);
        else if (rd_target_reg == reg_idx_t'(1))
            rd_value = encode_temp(held_local_reg, ext_range);
        else
            rd_value = rf_rd_data;
    end

    always_comb
    begin
        pending_next     = pending_reg;
        rd_target_next   = rd_target_reg;
        wr_target_next   = wr_target_reg;
        held_remote_next = held_remote_reg;
        held_local_next  = held_local_reg;
        rf_wr.en         = 1'b0;
        rf_wr.idx        = wr_target_reg;
        rf_wr.data       = s1_data_reg;

        if (s1_adv)
        begin
            unique case (s1_cmd_reg)
                CMD_ADDR:
                begin
                    if (s1_is_write_reg)
                        pending_next = 1'b1;
                end
                CMD_WRITE:
                begin
                    if (pending_reg)
                    begin
                        pending_next   = 1'b0;
                        rd_target_next = ptr_sel.rd;
                        wr_target_next = ptr_sel.wr;
                    end
                    else
                    begin
                        rf_wr.en = 1'b1;
                    end
                end
                CMD_READ:
                begin
                end
                CMD_TEMP:
                begin
                    held_remote_next = s1_remote_reg;
                    held_local_next  = s1_local_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        s1_valid_next = cmd_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);

        read_data_next = read_data_reg;
        if (s1_adv && s1_is_read)
        begin
            rsp_valid_next = 1'b1;
            read_data_next = rd_value;
        end
        else if (rsp_stall)
            rsp_valid_next = rsp_valid_reg;
        else
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            pending_reg     <= 1'b0;
            rd_target_reg   <= '0;
            wr_target_reg   <= '0;
            held_remote_reg <= '0;
            held_local_reg  <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg    <= s1_valid_next;
            pending_reg     <= pending_next;
            rd_target_reg   <= rd_target_next;
            wr_target_reg   <= wr_target_next;
            held_remote_reg <= held_remote_next;
            held_local_reg  <= held_local_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            s1_cmd_reg      <= command;
            s1_is_write_reg <= is_write;
            s1_data_reg     <= data_byte;
            s1_remote_reg   <= remote_reading;
            s1_local_reg    <= local_reading;
        end
        read_data_reg <= read_data_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign read_data = read_data_reg;

endmodule

`default_nettype wire

// ===== src/tsrm_checker.sv =====
`default_nettype none

module tsrm_checker
    import tsrm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    input  wire logic              cmd_stall,
    input  wire logic [1:0]        command,
    input  wire logic              rsp_valid,
    input  wire logic              rsp_stall,
    input  wire logic [7:0]        read_data
);

    // Input back-pressure only arises behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> (rsp_valid && rsp_stall))
        else $error("cmd_stall without a stalled result");

    // A fresh result follows a read transfer through the input stage and the result register
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(cmd_valid && !cmd_stall && (command == CMD_READ), 2))
        else $error("result without a matching read transfer");

    // Non-read transfers never produce a result on their own
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (!rsp_valid && !(cmd_valid && !cmd_stall && (command == CMD_READ)))
            |=> ##1 (!rsp_valid || $past(rsp_valid) || $past(cmd_stall)))
        else $error("result appeared with no read in flight");

    // Held result stays put
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(read_data)))
        else $error("stalled result changed");

endmodule

bind temp_sensor_slave_register_map tsrm_checker u_tsrm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .command     (command),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .read_data   (read_data)
);

`default_nettype wire
